FILE: src/cptu_pkg.sv
// Package holding the shared types, the pattern table and the grey-level helper.
`timescale 1ns / 1ps

package cptu_pkg;

   // Tile geometry.
   localparam int TILE_ROWS   = 4;
   localparam int TILE_COLS   = 4;
   localparam int TILE_PIXELS = TILE_ROWS * TILE_COLS;
   localparam int ROW_WIDTH   = $clog2(TILE_ROWS);
   localparam int COL_WIDTH   = $clog2(TILE_COLS);
   localparam int POS_WIDTH   = $clog2(TILE_PIXELS);
   localparam int GREY_WIDTH  = 8;

   localparam logic [ROW_WIDTH-1:0] LAST_ROW = ROW_WIDTH'(TILE_ROWS - 1);

   // Grey levels that the pattern table uses.
   localparam logic [GREY_WIDTH-1:0] GREY_DARK = 8'h00;
   localparam logic [GREY_WIDTH-1:0] GREY_HALF = 8'h80;
   localparam logic [GREY_WIDTH-1:0] GREY_FULL = 8'hFF;

   // Reset value of the explored colour register.
   localparam logic [GREY_WIDTH-1:0] EXPLORED_COLOR_RESET = 8'd64;

   // Compact pixel code held in the table and in the first stage.
   typedef logic [1:0] pix_code_type;

   localparam pix_code_type PC_0 = 2'd0;
   localparam pix_code_type PC_H = 2'd1;
   localparam pix_code_type PC_F = 2'd2;

   // Tile of pixel codes with its explored flags, bit row*4+column.
   typedef struct packed {
      pix_code_type [TILE_PIXELS-1:0] codes;
      logic [TILE_PIXELS-1:0]         mask;
   } coded_tile_type;

   // Tile of final grey levels, row-major.
   typedef logic [TILE_PIXELS-1:0][GREY_WIDTH-1:0] grey_tile_type;

   // Corner pattern table, indexed by {top_left, top_right, bottom_left, bottom_right}.
   localparam pix_code_type TILE_TABLE [16][TILE_PIXELS] = '{
      '{PC_0, PC_0, PC_0, PC_0,  PC_0, PC_0, PC_0, PC_0,
        PC_0, PC_0, PC_0, PC_0,  PC_0, PC_0, PC_0, PC_0},
      '{PC_0, PC_0, PC_0, PC_0,  PC_0, PC_0, PC_0, PC_0,
        PC_0, PC_0, PC_0, PC_H,  PC_0, PC_0, PC_H, PC_F},
      '{PC_0, PC_0, PC_0, PC_0,  PC_0, PC_0, PC_0, PC_0,
        PC_H, PC_0, PC_0, PC_0,  PC_F, PC_H, PC_0, PC_0},
      '{PC_0, PC_0, PC_0, PC_0,  PC_0, PC_0, PC_0, PC_0,
        PC_F, PC_F, PC_F, PC_F,  PC_F, PC_F, PC_F, PC_F},
      '{PC_0, PC_0, PC_H, PC_F,  PC_0, PC_0, PC_0, PC_H,
        PC_0, PC_0, PC_0, PC_0,  PC_0, PC_0, PC_0, PC_0},
      '{PC_0, PC_0, PC_F, PC_F,  PC_0, PC_0, PC_F, PC_F,
        PC_0, PC_0, PC_F, PC_F,  PC_0, PC_0, PC_F, PC_F},
      '{PC_0, PC_0, PC_H, PC_F,  PC_0, PC_0, PC_0, PC_H,
        PC_H, PC_0, PC_0, PC_0,  PC_F, PC_H, PC_0, PC_0},
      '{PC_0, PC_H, PC_F, PC_F,  PC_H, PC_F, PC_F, PC_F,
        PC_F, PC_F, PC_F, PC_F,  PC_F, PC_F, PC_F, PC_F},
      '{PC_F, PC_H, PC_0, PC_0,  PC_H, PC_0, PC_0, PC_0,
        PC_0, PC_0, PC_0, PC_0,  PC_0, PC_0, PC_0, PC_0},
      '{PC_F, PC_H, PC_0, PC_0,  PC_H, PC_0, PC_0, PC_0,
        PC_0, PC_0, PC_0, PC_H,  PC_0, PC_0, PC_H, PC_F},
      '{PC_F, PC_F, PC_0, PC_0,  PC_F, PC_F, PC_0, PC_0,
        PC_F, PC_F, PC_0, PC_0,  PC_F, PC_F, PC_0, PC_0},
      '{PC_F, PC_F, PC_H, PC_0,  PC_F, PC_F, PC_F, PC_H,
        PC_F, PC_F, PC_F, PC_F,  PC_F, PC_F, PC_F, PC_F},
      '{PC_F, PC_F, PC_F, PC_F,  PC_F, PC_F, PC_F, PC_F,
        PC_0, PC_0, PC_0, PC_0,  PC_0, PC_0, PC_0, PC_0},
      '{PC_F, PC_F, PC_F, PC_F,  PC_F, PC_F, PC_F, PC_F,
        PC_H, PC_F, PC_F, PC_F,  PC_0, PC_H, PC_F, PC_F},
      '{PC_F, PC_F, PC_F, PC_F,  PC_F, PC_F, PC_F, PC_F,
        PC_F, PC_F, PC_F, PC_H,  PC_F, PC_F, PC_H, PC_0},
      '{PC_F, PC_F, PC_F, PC_F,  PC_F, PC_F, PC_F, PC_F,
        PC_F, PC_F, PC_F, PC_F,  PC_F, PC_F, PC_F, PC_F}
   };

   // Turns a pixel code into its grey level; the unused code reads as dark.
   function automatic logic [GREY_WIDTH-1:0] code_to_grey(input pix_code_type code);
      logic [GREY_WIDTH-1:0] grey;
      case (code)
         PC_H:    grey = GREY_HALF;
         PC_F:    grey = GREY_FULL;
         default: grey = GREY_DARK;
      endcase
      return grey;
   endfunction

endpackage

FILE: src/cptu_lookup.sv
// First pipeline stage: looks up the corner pattern tile for one window.
`timescale 1ns / 1ps

module cptu_lookup
   import cptu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_stall,
   input  logic           top_left,
   input  logic           top_right,
   input  logic           bottom_left,
   input  logic           bottom_right,
   input  logic [15:0]    explored_mask,
   output logic           out_valid,
   input  logic           out_stall,
   output coded_tile_type out_tile
);

   logic           valid_ff;
   logic           valid_in;
   coded_tile_type tile_ff;
   coded_tile_type tile_in;
   logic [3:0]     pattern;

   // The stage holds its contents while the next stage cannot take them.
   assign in_stall = valid_ff & out_stall;

   // Table lookup on the four corner flags.
   always_comb begin
      pattern = {top_left, top_right, bottom_left, bottom_right};
      for (int pos = 0; pos < TILE_PIXELS; pos++) begin
         tile_in.codes[pos] = TILE_TABLE[pattern][pos];
      end
      tile_in.mask = explored_mask;
   end

   assign valid_in = in_stall ? valid_ff : in_valid;

   // Valid bit of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only when a transaction enters.
   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         tile_ff <= tile_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tile  = tile_ff;

endmodule

FILE: src/cptu_shade.sv
// Second pipeline stage: expands pixel codes to grey and fills explored dark pixels.
`timescale 1ns / 1ps

module cptu_shade
   import cptu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [GREY_WIDTH-1:0] explored_color,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  coded_tile_type        in_tile,
   output logic                  out_valid,
   input  logic                  out_stall,
   output grey_tile_type         out_tile
);

   logic          valid_ff;
   logic          valid_in;
   grey_tile_type tile_ff;
   grey_tile_type tile_in;

   assign in_stall = valid_ff & out_stall;

   // A dark pixel whose explored flag is set takes the explored colour.
   always_comb begin
      for (int pos = 0; pos < TILE_PIXELS; pos++) begin
         if (in_tile.codes[pos] == PC_0 && in_tile.mask[pos]) begin
            tile_in[pos] = explored_color;
         end else begin
            tile_in[pos] = code_to_grey(in_tile.codes[pos]);
         end
      end
   end

   assign valid_in = in_stall ? valid_ff : in_valid;

   // Valid bit of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only when a transaction enters.
   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         tile_ff <= tile_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tile  = tile_ff;

endmodule

FILE: src/cptu_serialiser.sv
// Final stage: holds one grey tile and sends it out one row per transaction.
`timescale 1ns / 1ps

module cptu_serialiser
   import cptu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  grey_tile_type         in_tile,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ROW_WIDTH-1:0]  rsp_row_index,
   output logic [GREY_WIDTH-1:0] rsp_pixel_0,
   output logic [GREY_WIDTH-1:0] rsp_pixel_1,
   output logic [GREY_WIDTH-1:0] rsp_pixel_2,
   output logic [GREY_WIDTH-1:0] rsp_pixel_3,
   output logic                  rsp_last_row
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ROW_WIDTH-1:0] row_ff;
   logic [ROW_WIDTH-1:0] row_in;
   grey_tile_type        tile_ff;
   logic                 row_taken;
   logic                 tile_done;
   logic                 load;

   // A row leaves on every transaction; the tile is done after its last row.
   assign row_taken = valid_ff & ~rsp_stall;
   assign tile_done = row_taken & (row_ff == LAST_ROW);
   assign in_stall  = valid_ff & ~tile_done;
   assign load      = in_valid & ~in_stall;

   // Row counter and valid bit.
   always_comb begin
      valid_in = valid_ff;
      row_in   = row_ff;
      if (load) begin
         valid_in = 1'b1;
         row_in   = '0;
      end else if (tile_done) begin
         valid_in = 1'b0;
      end else if (row_taken) begin
         row_in = row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         row_ff   <= row_in;
      end
   end

   // Tile buffer loads when the previous tile has gone.
   always_ff @(posedge clock) begin
      if (load) begin
         tile_ff <= in_tile;
      end
   end

   // Row selection from the held tile.
   assign rsp_valid     = valid_ff;
   assign rsp_row_index = row_ff;
   assign rsp_pixel_0   = tile_ff[{row_ff, COL_WIDTH'(0)}];
   assign rsp_pixel_1   = tile_ff[{row_ff, COL_WIDTH'(1)}];
   assign rsp_pixel_2   = tile_ff[{row_ff, COL_WIDTH'(2)}];
   assign rsp_pixel_3   = tile_ff[{row_ff, COL_WIDTH'(3)}];
   assign rsp_last_row  = (row_ff == LAST_ROW);

endmodule

FILE: src/corner_pattern_tile_upscaler.sv
// Top level of the corner pattern tile upscaler.
`timescale 1ns / 1ps

// Usage
// Each request transaction carries the four revealed flags of a 2x2 window
// and the sixteen explored flags of the matching 4x4 output tile. The block
// answers with four response transactions, rows 0 to 3 in order, each with
// four grey pixels; the fourth is marked with rsp_last_row.
// The user writes the explored colour register through csr_write_enable and
// csr_write_data while the block is idle; the block does not enforce it. It resets to 64.
// Pipeline: a request passes in turn through three register stages,
// pattern lookup, shading and the row serialiser, before its first row
// appears at the response port.
// Throughput: the serialiser sends one row per cycle while rsp_stall is low.
// Requests are taken in back-to-back cycles while the two earlier stages
// have room, so up to three tiles are in hand.
// Reset (synchronous, active high) empties every stage and drops any tile
// in flight. When the receiver stalls, the current row holds steady and the
// stall works back stage by stage to req_stall; nothing is lost or repeated.

module corner_pattern_tile_upscaler
   import cptu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_top_left,
   input  logic        req_top_right,
   input  logic        req_bottom_left,
   input  logic        req_bottom_right,
   input  logic [15:0] req_explored_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_row_index,
   output logic [7:0]  rsp_pixel_0,
   output logic [7:0]  rsp_pixel_1,
   output logic [7:0]  rsp_pixel_2,
   output logic [7:0]  rsp_pixel_3,
   output logic        rsp_last_row
);

   logic [GREY_WIDTH-1:0] explored_color_ff;
   logic [GREY_WIDTH-1:0] explored_color_in;
   logic                  coded_valid;
   logic                  coded_stall;
   coded_tile_type        coded_tile;
   logic                  grey_valid;
   logic                  grey_stall;
   grey_tile_type         grey_tile;

   // Explored colour register.
   assign explored_color_in = csr_write_enable ? csr_write_data : explored_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         explored_color_ff <= EXPLORED_COLOR_RESET;
      end else begin
         explored_color_ff <= explored_color_in;
      end
   end

   // Pattern lookup stage.
   cptu_lookup u_lookup (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_stall      (req_stall),
      .top_left      (req_top_left),
      .top_right     (req_top_right),
      .bottom_left   (req_bottom_left),
      .bottom_right  (req_bottom_right),
      .explored_mask (req_explored_mask),
      .out_valid     (coded_valid),
      .out_stall     (coded_stall),
      .out_tile      (coded_tile)
   );

   // Shading stage.
   cptu_shade u_shade (
      .clock          (clock),
      .reset          (reset),
      .explored_color (explored_color_ff),
      .in_valid       (coded_valid),
      .in_stall       (coded_stall),
      .in_tile        (coded_tile),
      .out_valid      (grey_valid),
      .out_stall      (grey_stall),
      .out_tile       (grey_tile)
   );

   // Row serialiser and response register.
   cptu_serialiser u_serialiser (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (grey_valid),
      .in_stall      (grey_stall),
      .in_tile       (grey_tile),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_row_index (rsp_row_index),
      .rsp_pixel_0   (rsp_pixel_0),
      .rsp_pixel_1   (rsp_pixel_1),
      .rsp_pixel_2   (rsp_pixel_2),
      .rsp_pixel_3   (rsp_pixel_3),
      .rsp_last_row  (rsp_last_row)
   );

endmodule
